/* src/lfsr_pitch_gate_sequencer_unit_macros.svh */
// Assertion macros shared by the sequencer RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef LFSR_PITCH_GATE_SEQUENCER_UNIT_MACROS_SVH
`define LFSR_PITCH_GATE_SEQUENCER_UNIT_MACROS_SVH

// check sampled on the clock, off during reset
`define LPGS_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// check sampled on the clock, active during reset as well
`define LPGS_ASSERT_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* src/lpgs_pkg.sv */
// Shared types, register codes and the major-scale table for the sequencer.
// No dependencies; imported by every RTL module of the block.
package lpgs_pkg;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam logic [2:0] REG_TAP_MASK       = 3'd0;
   localparam logic [2:0] REG_GATE_MASK      = 3'd1;
   localparam logic [2:0] REG_GALOIS_MODE    = 3'd2;
   localparam logic [2:0] REG_FOLLOW_MODE    = 3'd3;
   localparam logic [2:0] REG_CHROMATIC_MODE = 3'd4;
   localparam logic [2:0] REG_ROW_A_WEIGHTS  = 3'd5;
   localparam logic [2:0] REG_ROW_B_WEIGHTS  = 3'd6;
   localparam logic [2:0] REG_ROW_C_WEIGHTS  = 3'd7;

   typedef struct packed {
      logic        clock_edge;
      logic        clock_level;
      logic        reset_pulse;
      logic        run_toggle;
      logic [7:0]  bit_toggle_mask;
   } req_type;

   typedef struct packed {
      logic        gate_out;
      logic [6:0]  pitch_a;
      logic [6:0]  pitch_b;
      logic [6:0]  pitch_c;
      logic [7:0]  lfsr_value;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  tap_mask;
      logic [7:0]  gate_mask;
      logic        galois_mode;
      logic        follow_mode;
      logic        chromatic_mode;
      logic [23:0] row_a_weights;
      logic [23:0] row_b_weights;
      logic [23:0] row_c_weights;
   } cfg_type;

   // major scale degree -> semitone offset
   function automatic logic [3:0] major_step(input logic [2:0] degree);
      logic [3:0] semis;
      case (degree)
         3'd0: semis = 4'd0;
         3'd1: semis = 4'd2;
         3'd2: semis = 4'd4;
         3'd3: semis = 4'd5;
         3'd4: semis = 4'd7;
         3'd5: semis = 4'd9;
         3'd6: semis = 4'd11;
         default: semis = 4'd0;
      endcase
      return semis;
   endfunction

endpackage

/* src/lfsr_pitch_gate_sequencer_unit.sv */
// Top level of the LFSR pitch/gate step sequencer.
// Depends on lpgs_pkg, lpgs_csr, lpgs_step and the assertion macro header.
//
// One request word per audio sample produces one response word. A request is
// captured in an input register; when it may advance, the run flag, LFSR step,
// bit flips, gate and three pitches are worked out in one pass and written to
// the response register, where the response is then valid. Sustained
// throughput is one word per clock while rsp_ready stays high: the update of
// the LFSR, run flag and held pitches in one pass is the loop that sets it.
// The pipeline stalls only when the response register is full and rsp_ready
// is low. CHANNELS sets the LFSR length; taps, gate mask, flips and pitch
// weights reach only the low eight bits. Configure only while idle.
`include "lfsr_pitch_gate_sequencer_unit_macros.svh"

module lfsr_pitch_gate_sequencer_unit
   import lpgs_pkg::*;
#(
   parameter int CHANNELS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type cfg;
   req_type s1_data_ff;
   logic    s1_valid_ff;
   logic    s1_valid_in;
   rsp_type out_data_ff;
   rsp_type out_data_in;
   logic    out_valid_ff;
   logic    out_valid_in;
   logic    req_accept;
   logic    advance;

   lpgs_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   assign advance    = s1_valid_ff & (~out_valid_ff | rsp_ready);
   assign req_ready  = ~s1_valid_ff | advance;
   assign req_accept = req_valid & req_ready;

   lpgs_step #(
      .CHANNELS (CHANNELS)
   ) u_step (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .item   (s1_data_ff),
      .fire   (advance),
      .result (out_data_in)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   `LPGS_ASSERT(a_stall_blocks_input, s1_valid_ff && out_valid_ff && !rsp_ready |-> !req_ready, "input taken while both stages are full")
   `LPGS_ASSERT(a_advance_fills_output, advance |=> rsp_valid, "advanced word did not reach the response register")
   `LPGS_ASSERT(a_taken_word_retires, rsp_valid && rsp_ready && !advance |=> !rsp_valid, "response word repeated after being taken")
   `LPGS_ASSERT_ALWAYS(a_reset_empties, reset |=> !rsp_valid && !s1_valid_ff, "pipeline not empty after reset")

endmodule

/* src/lpgs_csr.sv */
// Configuration register file with an APB-style slave port.
// Depends on lpgs_pkg for the register codes and the cfg_type bundle.
module lpgs_csr
   import lpgs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [2:0] reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_idx = paddr[4:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_TAP_MASK:       cfg_in.tap_mask       = pwdata[7:0];
            REG_GATE_MASK:      cfg_in.gate_mask      = pwdata[7:0];
            REG_GALOIS_MODE:    cfg_in.galois_mode    = pwdata[0];
            REG_FOLLOW_MODE:    cfg_in.follow_mode    = pwdata[0];
            REG_CHROMATIC_MODE: cfg_in.chromatic_mode = pwdata[0];
            REG_ROW_A_WEIGHTS:  cfg_in.row_a_weights  = pwdata[23:0];
            REG_ROW_B_WEIGHTS:  cfg_in.row_b_weights  = pwdata[23:0];
            REG_ROW_C_WEIGHTS:  cfg_in.row_c_weights  = pwdata[23:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tap_mask       <= 8'h80;
         cfg_ff.gate_mask      <= 8'hff;
         cfg_ff.galois_mode    <= 1'b1;
         cfg_ff.follow_mode    <= 1'b1;
         cfg_ff.chromatic_mode <= 1'b0;
         cfg_ff.row_a_weights  <= 24'd0;
         cfg_ff.row_b_weights  <= 24'd0;
         cfg_ff.row_c_weights  <= 24'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_idx)
         REG_TAP_MASK:       prdata = {24'd0, cfg_ff.tap_mask};
         REG_GATE_MASK:      prdata = {24'd0, cfg_ff.gate_mask};
         REG_GALOIS_MODE:    prdata = {31'd0, cfg_ff.galois_mode};
         REG_FOLLOW_MODE:    prdata = {31'd0, cfg_ff.follow_mode};
         REG_CHROMATIC_MODE: prdata = {31'd0, cfg_ff.chromatic_mode};
         REG_ROW_A_WEIGHTS:  prdata = {8'd0, cfg_ff.row_a_weights};
         REG_ROW_B_WEIGHTS:  prdata = {8'd0, cfg_ff.row_b_weights};
         REG_ROW_C_WEIGHTS:  prdata = {8'd0, cfg_ff.row_c_weights};
         default:            prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

/* src/lpgs_pitch.sv */
// One pitch row: weighted sum of set register bits, then chromatic or
// major-scale mapping. Depends on lpgs_pkg for the scale table.
module lpgs_pitch
   import lpgs_pkg::*;
(
   input  logic [23:0] weights,
   input  logic [7:0]  bits,
   input  logic        chromatic,
   output logic [6:0]  pitch
);

   logic [5:0]  sum;
   logic [11:0] prod;
   logic [3:0]  octave;
   logic [6:0]  octave_x7;
   logic [6:0]  octave_x12;
   logic [2:0]  degree;

   always_comb begin
      sum = '0;
      for (int i = 0; i < 8; i++) begin
         if (bits[i]) begin
            sum = sum + {3'd0, weights[3*i +: 3]};
         end
      end
   end

   // sum / 7 as (sum * 37) >> 8, exact for sums below 64
   assign prod       = {6'd0, sum} * 12'd37;
   assign octave     = prod[11:8];
   assign octave_x7  = {octave, 3'b000} - {3'b000, octave};
   assign degree     = 3'(sum - octave_x7[5:0]);
   assign octave_x12 = {octave, 3'b000} + {1'b0, octave, 2'b00};

   assign pitch = chromatic ? {1'b0, sum}
                            : 7'(major_step(degree)) + octave_x12;

endmodule

/* src/lpgs_step.sv */
// Per-item datapath and sequencer state: run flag, LFSR step, bit flips,
// gate and held pitches. Depends on lpgs_pkg and lpgs_pitch.
module lpgs_step
   import lpgs_pkg::*;
#(
   parameter int CHANNELS = 8
) (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  req_type item,
   input  logic    fire,
   output rsp_type result
);

   logic [CHANNELS-1:0] shift_ff;
   logic [CHANNELS-1:0] shift_in;
   logic                running_ff;
   logic                running_in;
   logic [6:0]          held_a_ff, held_b_ff, held_c_ff;
   logic [6:0]          held_a_in, held_b_in, held_c_in;

   logic [CHANNELS-1:0] tap_w;
   logic [CHANNELS-1:0] gate_w;
   logic [CHANNELS-1:0] flip_w;
   logic [CHANNELS-1:0] stepped;
   logic                do_step;
   logic                gate;
   logic                load_pitch;
   logic [7:0]          low_bits;
   logic [6:0]          pitch_a, pitch_b, pitch_c;

   assign tap_w  = CHANNELS'(cfg.tap_mask);
   assign gate_w = CHANNELS'(cfg.gate_mask);
   assign flip_w = CHANNELS'(item.bit_toggle_mask);

   assign running_in = running_ff ^ item.run_toggle;
   assign do_step    = (running_in & item.clock_edge) | item.reset_pulse;

   always_comb begin
      if (cfg.galois_mode) begin
         stepped = shift_ff >> 1;
         if (shift_ff[0]) begin
            stepped = stepped ^ tap_w;
         end
      end else begin
         stepped = {^(shift_ff & tap_w), shift_ff[CHANNELS-1:1]};
      end
   end

   assign shift_in = (do_step ? stepped : shift_ff) ^ flip_w;
   assign low_bits = 8'(shift_in);

   lpgs_pitch u_pitch_a (
      .weights   (cfg.row_a_weights),
      .bits      (low_bits),
      .chromatic (cfg.chromatic_mode),
      .pitch     (pitch_a)
   );

   lpgs_pitch u_pitch_b (
      .weights   (cfg.row_b_weights),
      .bits      (low_bits),
      .chromatic (cfg.chromatic_mode),
      .pitch     (pitch_b)
   );

   lpgs_pitch u_pitch_c (
      .weights   (cfg.row_c_weights),
      .bits      (low_bits),
      .chromatic (cfg.chromatic_mode),
      .pitch     (pitch_c)
   );

   assign gate       = running_in & item.clock_level & (|(shift_in & gate_w));
   assign load_pitch = gate | cfg.follow_mode | ~running_in;

   assign held_a_in = load_pitch ? pitch_a : held_a_ff;
   assign held_b_in = load_pitch ? pitch_b : held_b_ff;
   assign held_c_in = load_pitch ? pitch_c : held_c_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff   <= CHANNELS'(8'h80);
         running_ff <= 1'b1;
         held_a_ff  <= '0;
         held_b_ff  <= '0;
         held_c_ff  <= '0;
      end else if (fire) begin
         shift_ff   <= shift_in;
         running_ff <= running_in;
         held_a_ff  <= held_a_in;
         held_b_ff  <= held_b_in;
         held_c_ff  <= held_c_in;
      end
   end

   assign result.gate_out   = gate;
   assign result.pitch_a    = held_a_in;
   assign result.pitch_b    = held_b_in;
   assign result.pitch_c    = held_c_in;
   assign result.lfsr_value = low_bits;

endmodule
